// ----- rtl/afed_pkg.sv -----
// ----------------------------------------------------------------------------
// afed_pkg
// Shared types and constants of the ACI frame event decoder.
// ----------------------------------------------------------------------------
package afed_pkg;

  localparam logic [7:0]  SYNC_BYTE = 8'hAA;

  localparam logic [15:0] OPC_LINK   = 16'h0014;
  localparam logic [15:0] OPC_CALL   = 16'h000A;
  localparam logic [15:0] OPC_PLAYER = 16'h000B;
  localparam logic [15:0] OPC_VOLUME = 16'h0020;
  localparam logic [15:0] OPC_TRACK  = 16'h0021;

  // Parameter byte values carried by the frames
  localparam logic [7:0] LINK_UP_VAL      = 8'h01;
  localparam logic [7:0] CALL_ST_IDLE     = 8'h00;
  localparam logic [7:0] CALL_ST_INCOMING = 8'h02;
  localparam logic [7:0] CALL_ST_OUTGOING = 8'h03;
  localparam logic [7:0] CALL_ST_ACTIVE   = 8'h04;
  localparam logic [7:0] PLAY_ST_PLAY     = 8'h01;
  localparam logic [7:0] PLAY_ST_PAUSE    = 8'h02;
  localparam logic [7:0] VOL_UNKNOWN      = 8'hFF;

  // Frame status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_EVENT    = 2'd1;
  localparam logic [1:0] ST_CHK_FAIL = 2'd2;
  localparam logic [1:0] ST_SHORT    = 2'd3;

  // Event codes
  localparam logic [3:0] EV_NONE         = 4'd0;
  localparam logic [3:0] EV_CONNECTED    = 4'd1;
  localparam logic [3:0] EV_DISCONNECTED = 4'd2;
  localparam logic [3:0] EV_INCOMING     = 4'd3;
  localparam logic [3:0] EV_REJECTED     = 4'd4;
  localparam logic [3:0] EV_VOL_UP       = 4'd5;
  localparam logic [3:0] EV_VOL_DOWN     = 4'd6;
  localparam logic [3:0] EV_TRACK        = 4'd7;
  localparam logic [3:0] EV_MUTE         = 4'd8;
  localparam logic [3:0] EV_PLAY_PAUSE   = 4'd9;
  localparam logic [3:0] EV_OUTGOING     = 4'd10;

  localparam logic [2:0] PARAM_COUNT_MAX = 3'd7;

  typedef enum logic [1:0] {
    CP_IDLE,
    CP_RINGING,
    CP_DIALLING,
    CP_TALKING
  } call_phase_t;

  // Session context kept across frames
  typedef struct packed {
    call_phase_t call_phase;
    logic        vol_baselined;
    logic [7:0]  last_volume;
  } ctx_t;

  // Kept fields of a finished frame
  typedef struct packed {
    logic [15:0] opcode;
    logic [2:0]  param_count;
    logic [7:0]  param_first;
    logic [7:0]  param_second;
    logic [7:0]  param_seventh;
  } frame_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [3:0]  event_code;
    logic [15:0] frame_opcode;
  } out_item_t;

endpackage

// ----- rtl/afed_in_if.sv -----
// ----------------------------------------------------------------------------
// afed_in_if
// Byte stream channel into the decoder.
// ----------------------------------------------------------------------------
interface afed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/afed_out_if.sv -----
// ----------------------------------------------------------------------------
// afed_out_if
// Frame result channel out of the decoder.
// ----------------------------------------------------------------------------
interface afed_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [3:0]  event_code;
  logic [15:0] frame_opcode;

  modport source (output valid, output frame_status, output event_code,
                  output frame_opcode, input ready);
  modport sink   (input valid, input frame_status, input event_code,
                  input frame_opcode, output ready);
endinterface

// ----- rtl/aci_frame_event_decoder.sv -----
// ----------------------------------------------------------------------------
// aci_frame_event_decoder
// Deframes ACI frames from a byte stream and reports one result per frame.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while ready is high. Each byte advances
// the deframer and, for a checksum byte or a length field below two, writes
// one result into the output register, or into the one-entry skid stage
// behind it when the register is full; the skid stage lets input flow while
// a result waits. Ready falls only when both the output register and the
// skid stage hold results. Bytes seen before a sync byte are dropped. Frames
// with a bad checksum report status 2 and leave the session context untouched.
module aci_frame_event_decoder (
  input  logic      clk,
  input  logic      rst,
  afed_in_if.sink   in_ch,
  afed_out_if.source out_ch
);
  import afed_pkg::*;

  typedef enum logic [2:0] {
    PH_SYNC,
    PH_SEQ,
    PH_LEN_L,
    PH_LEN_H,
    PH_OPC_L,
    PH_OPC_H,
    PH_PARAMS,
    PH_CHK
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  sum_acc, sum_acc_next;
  frame_t      frame, frame_next;
  ctx_t        ctx, ctx_next;

  logic        out_valid, out_valid_next;
  out_item_t   out_item, out_item_next;
  logic        skid_valid, skid_valid_next;
  out_item_t   skid_item, skid_item_next;

  logic        accept;
  logic        drain;
  logic        res_valid;
  out_item_t   res_item;
  logic [7:0]  b;
  logic [15:0] len;
  logic [3:0]  dec_event;
  ctx_t        dec_ctx;

  afed_frame_decode u_decode (
    .frame      (frame),
    .ctx        (ctx),
    .event_code (dec_event),
    .ctx_next   (dec_ctx)
  );

  assign in_ch.ready         = !skid_valid;
  assign accept              = in_ch.valid && in_ch.ready;
  assign drain               = out_valid && out_ch.ready;
  assign b                   = in_ch.rx_byte;
  assign len                 = {b, bytes_left[7:0]};

  assign out_ch.valid        = out_valid;
  assign out_ch.frame_status = out_item.frame_status;
  assign out_ch.event_code   = out_item.event_code;
  assign out_ch.frame_opcode = out_item.frame_opcode;

  // Deframer
  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    sum_acc_next    = sum_acc;
    frame_next      = frame;
    ctx_next        = ctx;
    res_valid       = 1'b0;
    res_item        = '0;
    if (accept) begin
      unique case (phase)
        PH_SYNC: begin
          if (b == SYNC_BYTE) begin
            bytes_left_next        = '0;
            sum_acc_next           = '0;
            frame_next.param_count = '0;
            phase_next             = PH_SEQ;
          end
        end
        PH_SEQ: begin
          sum_acc_next = b;
          phase_next   = PH_LEN_L;
        end
        PH_LEN_L: begin
          bytes_left_next = {8'd0, b};
          sum_acc_next    = sum_acc + b;
          phase_next      = PH_LEN_H;
        end
        PH_LEN_H: begin
          sum_acc_next = sum_acc + b;
          if (len[15:1] == 15'd0) begin
            // drop the frame and report the short length
            bytes_left_next        = '0;
            sum_acc_next           = '0;
            frame_next.param_count = '0;
            phase_next             = PH_SYNC;
            res_valid              = 1'b1;
            res_item.frame_status  = ST_SHORT;
            res_item.event_code    = EV_NONE;
            res_item.frame_opcode  = '0;
          end else begin
            bytes_left_next = len - 16'd2;
            phase_next      = PH_OPC_L;
          end
        end
        PH_OPC_L: begin
          frame_next.opcode = {8'd0, b};
          sum_acc_next      = sum_acc + b;
          phase_next        = PH_OPC_H;
        end
        PH_OPC_H: begin
          frame_next.opcode      = {b, frame.opcode[7:0]};
          sum_acc_next           = sum_acc + b;
          frame_next.param_count = '0;
          phase_next             = (bytes_left == 16'd0) ? PH_CHK : PH_PARAMS;
        end
        PH_PARAMS: begin
          if (frame.param_count == 3'd0)      frame_next.param_first   = b;
          else if (frame.param_count == 3'd1) frame_next.param_second  = b;
          else if (frame.param_count == 3'd6) frame_next.param_seventh = b;
          if (frame.param_count != PARAM_COUNT_MAX) begin
            frame_next.param_count = frame.param_count + 3'd1;
          end
          sum_acc_next    = sum_acc + b;
          bytes_left_next = bytes_left - 16'd1;
          if (bytes_left == 16'd1) phase_next = PH_CHK;
        end
        PH_CHK: begin
          res_valid = 1'b1;
          if (b == (~sum_acc + 8'd1)) begin
            ctx_next              = dec_ctx;
            res_item.event_code   = dec_event;
            res_item.frame_status = (dec_event != EV_NONE) ? ST_EVENT : ST_ACCEPTED;
          end else begin
            res_item.event_code   = EV_NONE;
            res_item.frame_status = ST_CHK_FAIL;
          end
          res_item.frame_opcode  = frame.opcode;
          bytes_left_next        = '0;
          sum_acc_next           = '0;
          frame_next.param_count = '0;
          phase_next             = PH_SYNC;
        end
        default: ;
      endcase
    end
  end

  // Output register with skid stage
  always_comb begin
    out_valid_next  = out_valid;
    out_item_next   = out_item;
    skid_valid_next = skid_valid;
    skid_item_next  = skid_item;
    if (drain) begin
      if (skid_valid) begin
        out_item_next   = skid_item;
        skid_valid_next = 1'b0;
      end else begin
        out_valid_next = 1'b0;
      end
    end
    if (res_valid) begin
      if (!out_valid_next) begin
        out_valid_next = 1'b1;
        out_item_next  = res_item;
      end else begin
        skid_valid_next = 1'b1;
        skid_item_next  = res_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item  <= out_item_next;
    skid_item <= skid_item_next;
    if (rst) begin
      phase                <= PH_SYNC;
      bytes_left           <= '0;
      sum_acc              <= '0;
      frame                <= '0;
      ctx.call_phase       <= CP_IDLE;
      ctx.vol_baselined    <= 1'b0;
      ctx.last_volume      <= VOL_UNKNOWN;
      out_valid            <= 1'b0;
      skid_valid           <= 1'b0;
    end else begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      sum_acc    <= sum_acc_next;
      frame      <= frame_next;
      ctx        <= ctx_next;
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

endmodule

// ----- rtl/afed_frame_decode.sv -----
// ----------------------------------------------------------------------------
// afed_frame_decode
// Maps the opcode and kept parameters of a good frame to an event code and
// the updated session context.
// ----------------------------------------------------------------------------
module afed_frame_decode (
  input  afed_pkg::frame_t frame,
  input  afed_pkg::ctx_t   ctx,
  output logic [3:0]       event_code,
  output afed_pkg::ctx_t   ctx_next
);
  import afed_pkg::*;

  always_comb begin
    event_code = EV_NONE;
    ctx_next   = ctx;
    unique case (frame.opcode)
      OPC_LINK: begin
        if (frame.param_count != 3'd0) begin
          ctx_next.call_phase    = CP_IDLE;
          ctx_next.vol_baselined = 1'b0;
          ctx_next.last_volume   = VOL_UNKNOWN;
          event_code = (frame.param_first == LINK_UP_VAL) ? EV_CONNECTED
                                                          : EV_DISCONNECTED;
        end
      end
      OPC_CALL: begin
        if (frame.param_count >= 3'd2) begin
          case (frame.param_second)
            CALL_ST_INCOMING: begin
              ctx_next.call_phase = CP_RINGING;
              event_code = EV_INCOMING;
            end
            CALL_ST_OUTGOING: begin
              ctx_next.call_phase = CP_DIALLING;
              event_code = EV_OUTGOING;
            end
            CALL_ST_ACTIVE: begin
              ctx_next.call_phase = CP_TALKING;
            end
            CALL_ST_IDLE: begin
              if (ctx.call_phase == CP_RINGING) event_code = EV_REJECTED;
              ctx_next.call_phase    = CP_IDLE;
              ctx_next.vol_baselined = 1'b0;
            end
            default: ;
          endcase
        end
      end
      OPC_PLAYER: begin
        if (frame.param_count == PARAM_COUNT_MAX &&
            (frame.param_seventh == PLAY_ST_PLAY ||
             frame.param_seventh == PLAY_ST_PAUSE)) begin
          event_code = EV_PLAY_PAUSE;
        end
      end
      OPC_VOLUME: begin
        if (frame.param_count != 3'd0) begin
          // hold volume silently during calls and until a baseline exists
          if (ctx.call_phase != CP_IDLE) begin
            ctx_next.last_volume = frame.param_first;
          end else if (!ctx.vol_baselined) begin
            ctx_next.last_volume   = frame.param_first;
            ctx_next.vol_baselined = 1'b1;
          end else if (frame.param_first == 8'd0 && ctx.last_volume != 8'd0) begin
            ctx_next.last_volume = 8'd0;
            event_code = EV_MUTE;
          end else if (frame.param_first > ctx.last_volume) begin
            ctx_next.last_volume = frame.param_first;
            event_code = EV_VOL_UP;
          end else if (frame.param_first < ctx.last_volume) begin
            ctx_next.last_volume = frame.param_first;
            event_code = EV_VOL_DOWN;
          end
        end
      end
      OPC_TRACK: begin
        event_code = EV_TRACK;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/afed_checker.sv -----
// ----------------------------------------------------------------------------
// afed_checker
// Port-level checks of the frame event decoder, bound to the top level.
// ----------------------------------------------------------------------------
module afed_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  frame_status,
  input logic [3:0]  event_code,
  input logic [15:0] frame_opcode
);
  import afed_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_status) &&
      $stable(event_code) && $stable(frame_opcode))
    else $error("result changed while stalled");

  a_event_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((frame_status == ST_EVENT) == (event_code != EV_NONE)))
    else $error("event code disagrees with frame status");

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == ST_SHORT |-> frame_opcode == 16'd0)
    else $error("short frame carries an opcode");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind aci_frame_event_decoder afed_checker u_afed_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .frame_status (out_ch.frame_status),
  .event_code   (out_ch.event_code),
  .frame_opcode (out_ch.frame_opcode)
);

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ACI frame event decoder.
// ----------------------------------------------------------------------------
// Bytes are streamed into the decoder through its input channel. Each
// accepted byte also runs through a local deframer and session tracker,
// which queues the frame report that the decoder should produce. Reports
// leaving the output channel are compared field by field with that queue.
// The tests cover framing corner cases, link and call handling, player and
// volume events, a long receiver stall, and random traffic under several
// idle patterns on both channels.
module tb;
  import afed_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int STALL_CYCLES = 80;
  localparam int PRINT_CAP    = 40;

  typedef enum logic [2:0] {
    DF_SYNC, DF_SEQ, DF_LEN_L, DF_LEN_H, DF_OPC_L, DF_OPC_H, DF_PARAMS, DF_CHK
  } deframe_t;

  logic clk;
  logic rst;

  afed_in_if  in_ch ();
  afed_out_if out_ch ();

  aci_frame_event_decoder uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Idle percentages of the two channels
  int send_idle_pct;
  int recv_idle_pct;
  int bytes_sent;
  int fail_count;
  int cycle_count;

  logic rx_stalled;
  event stall_kick;

  logic [7:0] param_buf[$];
  out_item_t  frame_reports_q[$];

  // Local copy of the deframer and session state
  deframe_t    df_state;
  logic [15:0] remain;
  logic [15:0] opc_r;
  logic [7:0]  sum_r;
  logic [2:0]  pcount_r;
  logic [7:0]  p_first;
  logic [7:0]  p_second;
  logic [7:0]  p_seventh;
  call_phase_t call_st;
  logic        vol_known;
  logic [7:0]  vol_last;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random idling, or a long hold while a stall is running
  always @(posedge clk) begin
    out_ch.ready <= !rx_stalled && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always begin
    @(stall_kick);
    rx_stalled <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    rx_stalled <= 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (fail_count < PRINT_CAP)
      $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    fail_count++;
  endtask

  function automatic void restart_frame();
    remain   = 16'h0000;
    sum_r    = 8'h00;
    pcount_r = 3'd0;
  endfunction

  // Apply a frame that passed its checksum to the session state
  function automatic logic [3:0] session_event();
    logic [3:0] ev;
    ev = EV_NONE;
    case (opc_r)
      OPC_LINK: if (pcount_r >= 3'd1) begin
        call_st   = CP_IDLE;
        vol_known = 1'b0;
        vol_last  = VOL_UNKNOWN;
        ev = (p_first == LINK_UP_VAL) ? EV_CONNECTED : EV_DISCONNECTED;
      end
      OPC_CALL: if (pcount_r >= 3'd2) begin
        if (p_second == CALL_ST_INCOMING) begin
          call_st = CP_RINGING;
          ev = EV_INCOMING;
        end else if (p_second == CALL_ST_OUTGOING) begin
          call_st = CP_DIALLING;
          ev = EV_OUTGOING;
        end else if (p_second == CALL_ST_ACTIVE) begin
          call_st = CP_TALKING;
        end else if (p_second == CALL_ST_IDLE) begin
          if (call_st == CP_RINGING) ev = EV_REJECTED;
          call_st   = CP_IDLE;
          vol_known = 1'b0;
        end
      end
      OPC_PLAYER: begin
        if (pcount_r == PARAM_COUNT_MAX &&
            (p_seventh == PLAY_ST_PLAY || p_seventh == PLAY_ST_PAUSE))
          ev = EV_PLAY_PAUSE;
      end
      OPC_VOLUME: if (pcount_r >= 3'd1) begin
        if (call_st != CP_IDLE) begin
          vol_last = p_first;
        end else if (!vol_known) begin
          vol_last  = p_first;
          vol_known = 1'b1;
        end else if (p_first == 8'h00 && vol_last > 8'h00) begin
          vol_last = 8'h00;
          ev = EV_MUTE;
        end else if (p_first > vol_last) begin
          vol_last = p_first;
          ev = EV_VOL_UP;
        end else if (p_first < vol_last) begin
          vol_last = p_first;
          ev = EV_VOL_DOWN;
        end
      end
      OPC_TRACK: ev = EV_TRACK;
      default: ;
    endcase
    return ev;
  endfunction

  // Advance the local deframer by one byte and queue any frame report
  function automatic void deframe_byte(input logic [7:0] b);
    out_item_t  rep;
    logic [3:0] ev;
    case (df_state)
      DF_SYNC: if (b == SYNC_BYTE) begin
        restart_frame();
        df_state = DF_SEQ;
      end
      DF_SEQ: begin
        sum_r    = b;
        df_state = DF_LEN_L;
      end
      DF_LEN_L: begin
        remain   = {8'h00, b};
        sum_r    = sum_r + b;
        df_state = DF_LEN_H;
      end
      DF_LEN_H: begin
        remain = {b, remain[7:0]};
        sum_r  = sum_r + b;
        if (remain < 16'd2) begin
          rep.frame_status = ST_SHORT;
          rep.event_code   = EV_NONE;
          rep.frame_opcode = 16'h0000;
          frame_reports_q.push_back(rep);
          restart_frame();
          df_state = DF_SYNC;
        end else begin
          remain   = remain - 16'd2;
          df_state = DF_OPC_L;
        end
      end
      DF_OPC_L: begin
        opc_r    = {8'h00, b};
        sum_r    = sum_r + b;
        df_state = DF_OPC_H;
      end
      DF_OPC_H: begin
        opc_r    = {b, opc_r[7:0]};
        sum_r    = sum_r + b;
        pcount_r = 3'd0;
        df_state = (remain == 16'h0000) ? DF_CHK : DF_PARAMS;
      end
      DF_PARAMS: begin
        if (pcount_r == 3'd0) p_first = b;
        else if (pcount_r == 3'd1) p_second = b;
        else if (pcount_r == 3'd6) p_seventh = b;
        if (pcount_r < PARAM_COUNT_MAX) pcount_r = pcount_r + 3'd1;
        sum_r  = sum_r + b;
        remain = remain - 16'd1;
        if (remain == 16'h0000) df_state = DF_CHK;
      end
      default: begin
        if (b == 8'(~sum_r + 8'd1)) begin
          ev = session_event();
          rep.frame_status = (ev != EV_NONE) ? ST_EVENT : ST_ACCEPTED;
          rep.event_code   = ev;
        end else begin
          rep.frame_status = ST_CHK_FAIL;
          rep.event_code   = EV_NONE;
        end
        rep.frame_opcode = opc_r;
        frame_reports_q.push_back(rep);
        restart_frame();
        df_state = DF_SYNC;
      end
    endcase
  endfunction

  // Check results first, then predict from the byte taken at this edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (frame_reports_q.size() == 0) begin
          report_mismatch("unexpected result, opcode", out_ch.frame_opcode, 16'h0);
        end else begin
          want = frame_reports_q.pop_front();
          if (out_ch.frame_status !== want.frame_status)
            report_mismatch("frame_status", 16'(out_ch.frame_status),
                            16'(want.frame_status));
          if (out_ch.event_code !== want.event_code)
            report_mismatch("event_code", 16'(out_ch.event_code), 16'(want.event_code));
          if (out_ch.frame_opcode !== want.frame_opcode)
            report_mismatch("frame_opcode", out_ch.frame_opcode, want.frame_opcode);
        end
      end
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.rx_byte);
    end
  end

  // Offer one byte, idling first at random; return once it is transferred
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Send a well-formed frame around param_buf, optionally with a bad checksum
  task automatic send_frame(input logic [15:0] opc, input bit corrupt);
    logic [15:0] len;
    logic [7:0]  seq;
    logic [7:0]  sum;
    len = 16'(param_buf.size() + 2);
    seq = 8'($urandom_range(0, 255));
    sum = seq + len[7:0] + len[15:8] + opc[7:0] + opc[15:8];
    send_byte(SYNC_BYTE);
    send_byte(seq);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    send_byte(opc[7:0]);
    send_byte(opc[15:8]);
    foreach (param_buf[i]) begin
      sum = sum + param_buf[i];
      send_byte(param_buf[i]);
    end
    sum = ~sum + 8'd1;
    if (corrupt) sum = sum ^ 8'(1 << $urandom_range(0, 7));
    send_byte(sum);
    param_buf.delete();
  endtask

  task automatic send_short(input logic [7:0] len_lo);
    send_byte(SYNC_BYTE);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(len_lo);
    send_byte(8'h00);
  endtask

  task automatic test_framing();
    // line noise ahead of the first sync
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_short(8'h00);
    send_short(8'h01);
    param_buf.delete();
    send_frame(OPC_TRACK, 1'b0);
    param_buf = '{LINK_UP_VAL};
    send_frame(OPC_LINK, 1'b1);
    // more parameters than the counter holds, unknown opcode
    param_buf = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88, 8'h99};
    send_frame(16'hFFFF, 1'b0);
  endtask

  task automatic test_link_and_call();
    param_buf.delete();
    send_frame(OPC_LINK, 1'b0);
    param_buf = '{LINK_UP_VAL};
    send_frame(OPC_LINK, 1'b0);
    param_buf = '{8'h00};
    send_frame(OPC_LINK, 1'b0);
    param_buf = '{CALL_ST_INCOMING};
    send_frame(OPC_CALL, 1'b0);
    param_buf = '{8'h00, CALL_ST_INCOMING};
    send_frame(OPC_CALL, 1'b0);
    param_buf = '{8'h00, CALL_ST_IDLE};
    send_frame(OPC_CALL, 1'b0);
    param_buf = '{8'h00, CALL_ST_OUTGOING};
    send_frame(OPC_CALL, 1'b0);
    param_buf = '{8'h00, CALL_ST_ACTIVE};
    send_frame(OPC_CALL, 1'b0);
    param_buf = '{8'h00, CALL_ST_IDLE};
    send_frame(OPC_CALL, 1'b0);
    param_buf = '{8'h00, 8'h07};
    send_frame(OPC_CALL, 1'b0);
  endtask

  task automatic test_player();
    param_buf = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, PLAY_ST_PLAY};
    send_frame(OPC_PLAYER, 1'b0);
    param_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, PLAY_ST_PAUSE};
    send_frame(OPC_PLAYER, 1'b0);
    param_buf = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03};
    send_frame(OPC_PLAYER, 1'b0);
    param_buf = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, PLAY_ST_PLAY};
    send_frame(OPC_PLAYER, 1'b0);
  endtask

  task automatic test_volume();
    param_buf.delete();
    send_frame(OPC_VOLUME, 1'b0);
    param_buf = '{8'd50};
    send_frame(OPC_VOLUME, 1'b0);
    param_buf = '{8'd60};
    send_frame(OPC_VOLUME, 1'b0);
    param_buf = '{8'd60};
    send_frame(OPC_VOLUME, 1'b0);
    param_buf = '{8'd40};
    send_frame(OPC_VOLUME, 1'b0);
    param_buf = '{8'd0};
    send_frame(OPC_VOLUME, 1'b0);
    param_buf = '{8'd0};
    send_frame(OPC_VOLUME, 1'b0);
    param_buf = '{8'd255};
    send_frame(OPC_VOLUME, 1'b0);
    // volume changes during a call update the level silently
    param_buf = '{8'h00, CALL_ST_INCOMING};
    send_frame(OPC_CALL, 1'b0);
    param_buf = '{8'd10};
    send_frame(OPC_VOLUME, 1'b0);
    param_buf = '{8'h00, CALL_ST_IDLE};
    send_frame(OPC_CALL, 1'b0);
    param_buf = '{8'd20};
    send_frame(OPC_VOLUME, 1'b0);
    param_buf = '{8'd30};
    send_frame(OPC_VOLUME, 1'b0);
    param_buf = '{LINK_UP_VAL};
    send_frame(OPC_LINK, 1'b0);
    param_buf = '{8'd0};
    send_frame(OPC_VOLUME, 1'b0);
  endtask

  // Hold the receiver off while short frames keep arriving back to back
  task automatic test_backpressure();
    -> stall_kick;
    repeat (12) send_short(8'($urandom_range(0, 1)));
    param_buf = '{8'd90};
    send_frame(OPC_VOLUME, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int          stop_at;
    int          pick;
    int          n;
    logic [15:0] opc;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 11) begin
        send_short(8'($urandom_range(0, 1)));
      end else begin
        case ($urandom_range(0, 5))
          0: opc = OPC_LINK;
          1: opc = OPC_CALL;
          2: opc = OPC_PLAYER;
          3: opc = OPC_VOLUME;
          4: opc = OPC_TRACK;
          default: opc = 16'($urandom_range(0, 65535));
        endcase
        if (opc == OPC_PLAYER) n = $urandom_range(5, 9);
        else if ($urandom_range(0, 99) < 80) n = $urandom_range(0, 3);
        else n = $urandom_range(4, 9);
        repeat (n) param_buf.push_back(8'($urandom_range(0, 255)));
        case (opc)
          OPC_LINK: if (n > 0 && $urandom_range(0, 1) == 1) param_buf[0] = LINK_UP_VAL;
          OPC_CALL: if (n > 1) begin
            case ($urandom_range(0, 4))
              0: param_buf[1] = CALL_ST_IDLE;
              1: param_buf[1] = CALL_ST_INCOMING;
              2: param_buf[1] = CALL_ST_OUTGOING;
              3: param_buf[1] = CALL_ST_ACTIVE;
              default: ;
            endcase
          end
          OPC_PLAYER: if (n > 6) begin
            case ($urandom_range(0, 2))
              0: param_buf[6] = PLAY_ST_PLAY;
              1: param_buf[6] = PLAY_ST_PAUSE;
              default: ;
            endcase
          end
          OPC_VOLUME: if (n > 0 && $urandom_range(0, 4) == 0) param_buf[0] = 8'h00;
          default: ;
        endcase
        send_frame(opc, $urandom_range(0, 99) < 10);
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    rx_stalled    = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 53;
    bytes_sent    = 0;
    fail_count    = 0;
    cycle_count   = 0;
    df_state      = DF_SYNC;
    opc_r         = 16'h0000;
    p_first       = 8'h00;
    p_second      = 8'h00;
    p_seventh     = 8'h00;
    call_st       = CP_IDLE;
    vol_known     = 1'b0;
    vol_last      = VOL_UNKNOWN;
    restart_frame();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_framing();
    test_link_and_call();
    test_player();
    test_volume();
    test_random_traffic(60);

    send_idle_pct = 53;
    recv_idle_pct = 25;
    test_random_traffic(60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_traffic(60);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frame_reports_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (frame_reports_q.size() != 0)
      report_mismatch("reports left over", 16'(frame_reports_q.size()), 16'h0);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
